>>> src/ffrm_pkg.sv
// ----------------------------------------------------------------------------
// ffrm_pkg: shared types and constants of the force request mixer
// Beat layouts, slot entry layout, item kinds, effect types, status codes.
// ----------------------------------------------------------------------------
package ffrm_pkg;

  // slot table geometry
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // endless duration of a constant request
  localparam logic [23:0] ENDLESS = 24'hFFFFFF;

  // shared divider geometry
  localparam int unsigned DIV_NW = 39;
  localparam int unsigned DIV_DW = 25;
  localparam int unsigned DIV_CW = $clog2(DIV_NW);

  // item kinds
  localparam logic [2:0] KIND_SUBMIT = 3'd0;
  localparam logic [2:0] KIND_SET    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;
  localparam logic [2:0] KIND_ENABLE = 3'd5;
  localparam logic [2:0] KIND_LOOKUP = 3'd6;

  // effect types
  localparam logic [1:0] EFF_CONST = 2'd0;
  localparam logic [1:0] EFF_FADE  = 2'd1;
  localparam logic [1:0] EFF_ALT   = 2'd2;
  localparam logic [1:0] EFF_BAD   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        request_id;
    logic               channel;
    logic [1:0]         effect_type;
    logic               start_second;
    logic signed [15:0] value_a;
    logic signed [15:0] value_b;
    logic [23:0]        period_a;
    logic [23:0]        period_b;
    logic [23:0]        duration;
    logic [15:0]        delta_time;
    logic               enable_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        assigned_id;
    logic               drive_valid;
    logic               drive_channel;
    logic signed [15:0] drive_level;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic [31:0]        ident;
    logic               channel;
    logic [1:0]         etype;
    logic               order;
    logic signed [15:0] level_a;
    logic signed [15:0] level_b;
    logic [23:0]        span_a;
    logic [23:0]        span_b;
    logic [24:0]        limit;
    logic [24:0]        progress;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> src/force_feedback_request_mixer.sv
// ----------------------------------------------------------------------------
// force_feedback_request_mixer: two-channel rumble request mixer
// Keeps a table of force requests in a ram and mixes them per channel.
// ----------------------------------------------------------------------------
// Usage: one input beat per command (submit, set level, remove, tick, clear,
// enable, look up) on in_valid_i/in_ready_o. Each command yields one or two
// output beats on out_valid_o/out_ready_i; the last carries last_result.
// Extra beats carry the new drive level of a channel that changed, channel 0
// first. Slot fields live in one single-port-read ram, valid bits in flops.
// An id search steps through the slots and stops at a hit. A mix pass visits
// every slot and uses the shared divider for each fading slot with a positive
// level and for each alternating phase wrap on a tick. The input is closed
// while a command is in progress; the first result beat is valid the cycle
// after the output state loads it. One command at a time.
// A stalled receiver lets one more command in; its results wait in the
// output state until the buffer drains, and the input stays closed until then.
// Reset empties the table, zeroes both levels, enables force and sets the
// next id to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module force_feedback_request_mixer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ffrm_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ffrm_pkg::out_t  out_data_o
);
  import ffrm_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FRD   = 4'd1;
  localparam logic [3:0] ST_FCHK  = 4'd2;
  localparam logic [3:0] ST_FDONE = 4'd3;
  localparam logic [3:0] ST_VRD   = 4'd4;
  localparam logic [3:0] ST_VLD   = 4'd5;
  localparam logic [3:0] ST_AGE   = 4'd6;
  localparam logic [3:0] ST_MODW  = 4'd7;
  localparam logic [3:0] ST_WB    = 4'd8;
  localparam logic [3:0] ST_VAL   = 4'd9;
  localparam logic [3:0] ST_MUL   = 4'd10;
  localparam logic [3:0] ST_DIVW  = 4'd11;
  localparam logic [3:0] ST_ACC   = 4'd12;
  localparam logic [3:0] ST_APPLY = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  // control state
  logic [3:0]         state_q, state_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic               en_q, en_d;
  logic [31:0]        next_id_q, next_id_d;
  logic signed [15:0] lvl_q [2];
  logic signed [15:0] lvl_d [2];
  logic [1:0]         ocnt_q, ocnt_d;
  logic               ohead_q, ohead_d;

  // payload state
  in_t                req_q, req_d;
  entry_t             ent_q, ent_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic [SLOT_W-1:0]  fidx_q, fidx_d;
  logic [SLOT_W-1:0]  free_q, free_d;
  logic               found_q, found_d;
  logic               has_free_q, has_free_d;
  logic [31:0]        key_q, key_d;
  logic [1:0]         mask_q, mask_d;
  logic               age_q, age_d;
  logic [15:0]        delta_q, delta_d;
  logic signed [15:0] best_q [2];
  logic signed [15:0] best_d [2];
  logic signed [15:0] val_q, val_d;
  logic [DIV_NW-1:0]  prod_q, prod_d;
  logic [1:0]         status_q, status_d;
  logic [31:0]        aid_q, aid_d;
  logic [1:0]         rcnt_q, rcnt_d;
  logic               rch_q [2];
  logic               rch_d [2];
  logic signed [15:0] rlv_q [2];
  logic signed [15:0] rlv_d [2];
  out_t               obuf_q [2];
  out_t               obuf_d [2];

  // ram and divider hookup
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_ent;
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;
  logic [DIV_DW-1:0] div_rem;

  assign rd_ent = entry_t'(ram_rdata);

  ffrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  ffrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // sequencer
  always_comb begin
    logic              find_next;
    logic              slot_next;
    logic [1:0]        n;
    logic [24:0]       sum;
    logic [25:0]       t;
    logic [25:0]       e;
    logic [24:0]       d25;
    logic [24:0]       left;
    logic              expired;

    state_d    = state_q;
    valid_d    = valid_q;
    en_d       = en_q;
    next_id_d  = next_id_q;
    lvl_d      = lvl_q;
    ocnt_d     = ocnt_q;
    ohead_d    = ohead_q;
    req_d      = req_q;
    ent_d      = ent_q;
    idx_d      = idx_q;
    fidx_d     = fidx_q;
    free_d     = free_q;
    found_d    = found_q;
    has_free_d = has_free_q;
    key_d      = key_q;
    mask_d     = mask_q;
    age_d      = age_q;
    delta_d    = delta_q;
    best_d     = best_q;
    val_d      = val_q;
    prod_d     = prod_q;
    status_d   = status_q;
    aid_d      = aid_q;
    rcnt_d     = rcnt_q;
    rch_d      = rch_q;
    rlv_d      = rlv_q;
    obuf_d     = obuf_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = ent_q;
    div_start    = 1'b0;
    div_dividend = prod_q;
    div_divisor  = ent_q.limit;
    find_next  = 1'b0;
    slot_next  = 1'b0;
    n          = '0;
    sum        = 25'({1'b0, ent_q.span_a} + {1'b0, ent_q.span_b});
    t          = 26'({1'b0, ent_q.progress} + {10'b0, delta_q});
    e          = t;
    d25        = {9'b0, delta_q};
    left       = ent_q.limit - ent_q.progress;
    expired    = 1'b0;

    // output beat pops
    if (out_valid_o && out_ready_i) begin
      ocnt_d  = ocnt_q - 1'b1;
      ohead_d = ~ohead_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_data_i;
          status_d   = STAT_OK;
          aid_d      = '0;
          rcnt_d     = '0;
          idx_d      = '0;
          found_d    = 1'b0;
          has_free_d = 1'b0;
          best_d[0]  = '0;
          best_d[1]  = '0;
          mask_d     = 2'b11;
          age_d      = 1'b0;
          delta_d    = '0;
          case (in_data_i.kind)
            KIND_SUBMIT: begin
              if (in_data_i.effect_type == EFF_BAD) begin
                status_d = STAT_MISS;
                state_d  = ST_OUT;
              end else begin
                key_d   = next_id_q;
                state_d = ST_FRD;
              end
            end
            KIND_SET, KIND_REMOVE, KIND_LOOKUP: begin
              key_d   = in_data_i.request_id;
              state_d = ST_FRD;
            end
            KIND_TICK: begin
              age_d   = 1'b1;
              delta_d = in_data_i.delta_time;
              state_d = ST_VRD;
            end
            KIND_CLEAR: begin
              valid_d = '0;
              age_d   = 1'b1;
              state_d = ST_VRD;
            end
            KIND_ENABLE: begin
              en_d = in_data_i.enable_value;
              if (in_data_i.enable_value) begin
                state_d = ST_VRD;
              end else begin
                rcnt_d   = 2'd2;
                rch_d[0] = 1'b0;
                rch_d[1] = 1'b1;
                rlv_d[0] = '0;
                rlv_d[1] = '0;
                lvl_d[0] = '0;
                lvl_d[1] = '0;
                state_d  = ST_OUT;
              end
            end
            default: state_d = ST_OUT;
          endcase
        end
      end

      // id search, noting the lowest free slot on the way
      ST_FRD: begin
        if (valid_q[idx_q]) begin
          state_d = ST_FCHK;
        end else begin
          if (!has_free_q) begin
            has_free_d = 1'b1;
            free_d     = idx_q;
          end
          find_next = 1'b1;
        end
      end
      ST_FCHK: begin
        if (rd_ent.ident == key_q) begin
          found_d = 1'b1;
          fidx_d  = idx_q;
          ent_d   = rd_ent;
          state_d = ST_FDONE;
        end else begin
          find_next = 1'b1;
        end
      end

      ST_FDONE: begin
        idx_d = '0;
        case (req_q.kind)
          KIND_SUBMIT: begin
            if (found_q || has_free_q) begin
              next_id_d = (key_q + 32'd1 == '0) ? 32'd1 : key_q + 32'd1;
              aid_d     = key_q;
              if (found_q) begin
                status_d = STAT_MISS;
              end else begin
                ram_we             = 1'b1;
                ram_waddr          = free_q;
                ram_wdata.ident    = key_q;
                ram_wdata.channel  = req_q.channel;
                ram_wdata.etype    = req_q.effect_type;
                ram_wdata.order    = req_q.start_second;
                ram_wdata.level_a  = req_q.value_a;
                ram_wdata.level_b  = req_q.value_b;
                ram_wdata.span_a   = req_q.period_a;
                ram_wdata.span_b   = req_q.period_b;
                ram_wdata.limit    = {1'b0, req_q.duration};
                ram_wdata.progress = '0;
                valid_d[free_q]    = 1'b1;
              end
              mask_d  = req_q.channel ? 2'b10 : 2'b01;
              state_d = en_q ? ST_VRD : ST_OUT;
            end else begin
              status_d = STAT_FULL;
              state_d  = ST_OUT;
            end
          end
          KIND_SET, KIND_REMOVE: begin
            if (!found_q) begin
              status_d = STAT_MISS;
              state_d  = ST_OUT;
            end else begin
              if (req_q.kind == KIND_SET) begin
                ram_we    = 1'b1;
                ram_waddr = fidx_q;
                if (ent_q.etype == EFF_ALT) begin
                  ram_wdata.order = 1'b0;
                end else begin
                  ram_wdata.level_a = req_q.value_a;
                end
              end else begin
                valid_d[fidx_q] = 1'b0;
              end
              mask_d  = ent_q.channel ? 2'b10 : 2'b01;
              state_d = en_q ? ST_VRD : ST_OUT;
            end
          end
          default: begin
            if (found_q) begin
              aid_d = key_q;
            end else begin
              status_d = STAT_MISS;
            end
            state_d = ST_OUT;
          end
        endcase
      end

      // mix pass over valid slots
      ST_VRD: begin
        if (valid_q[idx_q]) begin
          state_d = ST_VLD;
        end else begin
          slot_next = 1'b1;
        end
      end
      ST_VLD: begin
        ent_d   = rd_ent;
        state_d = age_q ? ST_AGE : ST_VAL;
      end
      ST_AGE: begin
        state_d = ST_WB;
        case (ent_q.etype)
          EFF_CONST: begin
            if (ent_q.limit != {1'b0, ENDLESS}) begin
              ent_d.limit = (ent_q.limit > d25) ? ent_q.limit - d25 : '0;
            end
          end
          EFF_FADE: begin
            ent_d.progress = (e > {2'b0, ENDLESS}) ? {1'b0, ENDLESS} : e[24:0];
          end
          default: begin
            if (sum == '0) begin
              ent_d.progress = '0;
            end else if (t < {1'b0, sum}) begin
              ent_d.progress = t[24:0];
            end else begin
              div_start    = 1'b1;
              div_dividend = DIV_NW'(t);
              div_divisor  = sum;
              state_d      = ST_MODW;
            end
          end
        endcase
      end
      ST_MODW: begin
        if (div_done) begin
          ent_d.progress = div_rem;
          state_d        = ST_WB;
        end
      end
      ST_WB: begin
        ram_we  = 1'b1;
        expired = (ent_q.etype == EFF_CONST) ? (ent_q.limit == '0)
                                             : (ent_q.progress >= ent_q.limit);
        if (expired) begin
          valid_d[idx_q] = 1'b0;
          slot_next      = 1'b1;
        end else if (en_q) begin
          state_d = ST_VAL;
        end else begin
          slot_next = 1'b1;
        end
      end
      ST_VAL: begin
        state_d = ST_ACC;
        case (ent_q.etype)
          EFF_FADE: begin
            if (ent_q.level_a > 16'sd0 && ent_q.limit != '0 &&
                ent_q.progress < ent_q.limit) begin
              prod_d  = DIV_NW'(ent_q.level_a[14:0] * left[23:0]);
              state_d = ST_MUL;
            end else begin
              val_d = '0;
            end
          end
          EFF_ALT: begin
            if (ent_q.order) begin
              val_d = ({1'b0, ent_q.span_b} > ent_q.progress) ? ent_q.level_b
                                                              : ent_q.level_a;
            end else begin
              val_d = ({1'b0, ent_q.span_a} > ent_q.progress) ? ent_q.level_a
                                                              : ent_q.level_b;
            end
          end
          default: val_d = ent_q.level_a;
        endcase
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          val_d   = $signed(div_quo[15:0]);
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (val_q > best_q[ent_q.channel]) begin
          best_d[ent_q.channel] = val_q;
        end
        slot_next = 1'b1;
      end

      // commit channel levels and queue drive beats
      ST_APPLY: begin
        if (en_q) begin
          for (int c = 0; c < 2; c++) begin
            if (mask_q[c] && best_q[c] != lvl_q[c]) begin
              lvl_d[c] = best_q[c];
              rch_d[n[0]] = c[0];
              rlv_d[n[0]] = best_q[c];
              n = n + 2'd1;
            end
          end
        end else if (age_q) begin
          lvl_d[0] = '0;
          lvl_d[1] = '0;
        end
        rcnt_d  = n;
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (ocnt_q == '0) begin
          obuf_d[0].status        = status_q;
          obuf_d[0].assigned_id   = aid_q;
          obuf_d[0].drive_valid   = rcnt_q != '0;
          obuf_d[0].drive_channel = (rcnt_q != '0) ? rch_q[0] : 1'b0;
          obuf_d[0].drive_level   = (rcnt_q != '0) ? rlv_q[0] : 16'sd0;
          obuf_d[0].last_result   = rcnt_q != 2'd2;
          obuf_d[1].status        = status_q;
          obuf_d[1].assigned_id   = aid_q;
          obuf_d[1].drive_valid   = 1'b1;
          obuf_d[1].drive_channel = rch_q[1];
          obuf_d[1].drive_level   = rlv_q[1];
          obuf_d[1].last_result   = 1'b1;
          ocnt_d  = (rcnt_q == 2'd2) ? 2'd2 : 2'd1;
          ohead_d = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // slot stepping
    if (find_next) begin
      if (idx_q == LAST) begin
        state_d = ST_FDONE;
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = ST_FRD;
      end
    end
    if (slot_next) begin
      if (idx_q == LAST) begin
        state_d = ST_APPLY;
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = ST_VRD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      en_q      <= 1'b1;
      next_id_q <= 32'd1;
      lvl_q[0]  <= '0;
      lvl_q[1]  <= '0;
      ocnt_q    <= '0;
      ohead_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      en_q      <= en_d;
      next_id_q <= next_id_d;
      lvl_q     <= lvl_d;
      ocnt_q    <= ocnt_d;
      ohead_q   <= ohead_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ent_q      <= ent_d;
    idx_q      <= idx_d;
    fidx_q     <= fidx_d;
    free_q     <= free_d;
    found_q    <= found_d;
    has_free_q <= has_free_d;
    key_q      <= key_d;
    mask_q     <= mask_d;
    age_q      <= age_d;
    delta_q    <= delta_d;
    best_q     <= best_d;
    val_q      <= val_d;
    prod_q     <= prod_d;
    status_q   <= status_d;
    aid_q      <= aid_d;
    rcnt_q     <= rcnt_d;
    rch_q      <= rch_d;
    rlv_q      <= rlv_d;
    obuf_q     <= obuf_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = ocnt_q != '0;
  assign out_data_o  = obuf_q[ohead_q];

  // checks
  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q != 2'd3) else $error("output buffer count out of range");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && ocnt_q == '0) |=> out_valid_o && in_ready_o)
    else $error("results not loaded into output buffer");

  a_lvl_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lvl_q[0][15] && !lvl_q[1][15]) else $error("negative channel level");

endmodule

>>> src/ffrm_ram.sv
// ----------------------------------------------------------------------------
// ffrm_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/ffrm_div.sv
// ----------------------------------------------------------------------------
// ffrm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module ffrm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ffrm_pkg::DIV_NW-1:0] dividend_i,
  input  logic [ffrm_pkg::DIV_DW-1:0] divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [ffrm_pkg::DIV_NW-1:0] quo_o,
  output logic [ffrm_pkg::DIV_DW-1:0] rem_o
);
  import ffrm_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_DW-1:0] dsr_q, dsr_d;
  logic [DIV_DW:0]   shifted;
  logic              ge;

  // one restoring step
  assign shifted = {rem_q, quo_q[DIV_NW-1]};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_NW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_NW-2:0], ge};
      rem_d = ge ? DIV_DW'(shifted - {1'b0, dsr_q}) : shifted[DIV_DW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the force request mixer
// Drives submit, set level, remove, tick, clear, enable and look up commands,
// predicts every result beat in a local table model and checks them in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffrm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  force_feedback_request_mixer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the request table
  logic               m_valid    [SLOTS];
  logic [31:0]        m_ident    [SLOTS];
  logic               m_channel  [SLOTS];
  logic [1:0]         m_etype    [SLOTS];
  logic               m_order    [SLOTS];
  logic signed [15:0] m_level_a  [SLOTS];
  logic signed [15:0] m_level_b  [SLOTS];
  logic [23:0]        m_span_a   [SLOTS];
  logic [23:0]        m_span_b   [SLOTS];
  logic [24:0]        m_limit    [SLOTS];
  logic [24:0]        m_progress [SLOTS];
  logic signed [15:0] m_chan_level [2];
  logic               m_enabled;
  logic [31:0]        m_next_id;

  int                 drv_count;
  logic               drv_chan [2];
  logic signed [15:0] drv_level [2];

  in_t  pending_items [$];
  out_t expected_beats [$];
  int   mismatches;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_sender;

  function automatic void mix_reset();
    for (int i = 0; i < SLOTS; i++) m_valid[i] = 1'b0;
    m_chan_level[0] = '0;
    m_chan_level[1] = '0;
    m_enabled = 1'b1;
    m_next_id = 32'd1;
  endfunction

  function automatic int find_request(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && m_ident[i] == id) return i;
    return -1;
  endfunction

  function automatic logic signed [15:0] request_level(int i);
    longint prod;
    if (m_etype[i] == EFF_FADE) begin
      if (m_limit[i] == 0 || m_progress[i] >= m_limit[i]) return '0;
      prod = longint'(m_level_a[i]) * longint'(m_limit[i] - m_progress[i]);
      return 16'(prod / longint'(m_limit[i]));
    end
    if (m_etype[i] == EFF_ALT) begin
      if (m_order[i])
        return ({1'b0, m_span_b[i]} > m_progress[i]) ? m_level_b[i] : m_level_a[i];
      return ({1'b0, m_span_a[i]} > m_progress[i]) ? m_level_a[i] : m_level_b[i];
    end
    return m_level_a[i];
  endfunction

  function automatic void push_level(logic ch, logic signed [15:0] lv);
    if (drv_count < 2) begin
      drv_chan[drv_count]  = ch;
      drv_level[drv_count] = lv;
      drv_count++;
    end
  endfunction

  function automatic void remix_channel(logic ch);
    logic signed [15:0] best;
    logic signed [15:0] v;
    best = '0;
    if (!m_enabled) return;
    for (int i = 0; i < SLOTS; i++)
      if (m_valid[i] && m_channel[i] == ch) begin
        v = request_level(i);
        if (v > best) best = v;
      end
    if (best != m_chan_level[ch]) begin
      m_chan_level[ch] = best;
      push_level(ch, best);
    end
  endfunction

  // ages one request, returns 1 when it has expired
  function automatic bit age_request(int i, logic [15:0] d);
    logic [25:0] sum;
    logic [25:0] e;
    if (m_etype[i] == EFF_CONST) begin
      if (m_limit[i] != {1'b0, ENDLESS})
        m_limit[i] = (m_limit[i] > d) ? m_limit[i] - d : '0;
      return m_limit[i] == 0;
    end
    if (m_etype[i] == EFF_FADE) begin
      e = m_progress[i] + d;
      m_progress[i] = (e > ENDLESS) ? {1'b0, ENDLESS} : e[24:0];
    end else begin
      sum = m_span_a[i] + m_span_b[i];
      m_progress[i] = (sum != 0) ? 25'((26'(m_progress[i]) + d) % sum) : '0;
    end
    return m_progress[i] >= m_limit[i];
  endfunction

  function automatic void age_all(logic [15:0] d);
    logic signed [15:0] prev [2];
    logic signed [15:0] v;
    prev[0] = m_chan_level[0];
    prev[1] = m_chan_level[1];
    m_chan_level[0] = '0;
    m_chan_level[1] = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!m_valid[i]) continue;
      if (age_request(i, d)) m_valid[i] = 1'b0;
      else if (m_enabled) begin
        v = request_level(i);
        if (v > m_chan_level[m_channel[i]]) m_chan_level[m_channel[i]] = v;
      end
    end
    if (m_enabled)
      for (int c = 0; c < 2; c++)
        if (prev[c] != m_chan_level[c]) push_level(c[0], m_chan_level[c]);
  endfunction

  // predicts the result beats of one command and queues them
  function automatic void predict_mix(in_t it);
    logic [1:0]  st;
    logic [31:0] aid;
    logic [31:0] id;
    int          idx;
    int          n;
    out_t        r;
    st = STAT_OK;
    aid = '0;
    drv_count = 0;
    case (it.kind)
      KIND_SUBMIT: begin
        if (it.effect_type == EFF_BAD) st = STAT_MISS;
        else begin
          id = m_next_id;
          if (find_request(id) >= 0) begin
            m_next_id = (id + 1 == 0) ? 32'd1 : id + 1;
            st = STAT_MISS;
            aid = id;
            remix_channel(it.channel);
          end else begin
            idx = -1;
            for (int i = 0; i < SLOTS; i++)
              if (!m_valid[i]) begin
                idx = i;
                break;
              end
            if (idx < 0) st = STAT_FULL;
            else begin
              m_next_id = (id + 1 == 0) ? 32'd1 : id + 1;
              aid = id;
              m_valid[idx]    = 1'b1;
              m_ident[idx]    = id;
              m_channel[idx]  = it.channel;
              m_etype[idx]    = it.effect_type;
              m_order[idx]    = it.start_second;
              m_level_a[idx]  = it.value_a;
              m_level_b[idx]  = it.value_b;
              m_span_a[idx]   = it.period_a;
              m_span_b[idx]   = it.period_b;
              m_limit[idx]    = {1'b0, it.duration};
              m_progress[idx] = '0;
              remix_channel(it.channel);
            end
          end
        end
      end
      KIND_SET: begin
        idx = find_request(it.request_id);
        if (idx < 0) st = STAT_MISS;
        else begin
          if (m_etype[idx] == EFF_ALT) m_order[idx] = 1'b0;
          else m_level_a[idx] = it.value_a;
          remix_channel(m_channel[idx]);
        end
      end
      KIND_REMOVE: begin
        idx = find_request(it.request_id);
        if (idx < 0) st = STAT_MISS;
        else begin
          m_valid[idx] = 1'b0;
          remix_channel(m_channel[idx]);
        end
      end
      KIND_TICK: age_all(it.delta_time);
      KIND_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) m_valid[i] = 1'b0;
        age_all('0);
      end
      KIND_ENABLE: begin
        m_enabled = it.enable_value;
        if (m_enabled) begin
          remix_channel(1'b0);
          remix_channel(1'b1);
        end else begin
          push_level(1'b0, '0);
          push_level(1'b1, '0);
          m_chan_level[0] = '0;
          m_chan_level[1] = '0;
        end
      end
      KIND_LOOKUP: begin
        if (find_request(it.request_id) >= 0) aid = it.request_id;
        else st = STAT_MISS;
      end
      default: ;
    endcase
    n = (drv_count > 0) ? drv_count : 1;
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.status = st;
      r.assigned_id = aid;
      if (k < drv_count) begin
        r.drive_valid   = 1'b1;
        r.drive_channel = drv_chan[k];
        r.drive_level   = drv_level[k];
      end
      r.last_result = (k == n - 1);
      expected_beats.push_back(r);
    end
  endfunction

  // stimulus builders
  function automatic in_t noise_item();
    in_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return it;
  endfunction

  function automatic logic [23:0] pick_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ENDLESS;
      2: return 24'($urandom);
      default: return 24'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic in_t submit_item(logic [1:0] et);
    in_t it;
    it = noise_item();
    it.kind = KIND_SUBMIT;
    it.effect_type = et;
    it.duration = pick_time();
    it.period_a = ($urandom_range(0, 3) == 0) ? pick_time() : 24'($urandom_range(0, 60));
    it.period_b = ($urandom_range(0, 3) == 0) ? pick_time() : 24'($urandom_range(0, 60));
    return it;
  endfunction

  // id near the live ones so that hits are common
  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return '0;
      default: return m_next_id - 32'($urandom_range(1, 20));
    endcase
  endfunction

  function automatic in_t op_item(logic [2:0] k);
    in_t it;
    it = noise_item();
    it.kind = k;
    it.request_id = pick_id();
    if ($urandom_range(0, 3) != 0) it.delta_time = 16'($urandom_range(0, 80));
    if (k == KIND_ENABLE && $urandom_range(0, 3) != 0) it.enable_value = 1'b1;
    return it;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // prediction on acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) predict_mix(in_data);
  end

  // receiver stalls
  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        exp_beat = expected_beats.pop_front();
        if (out_data !== exp_beat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_beat, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_items.size() == 0 && !in_valid && expected_beats.size() == 0))
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
  endtask

  function automatic void queue_random(int count);
    int r;
    for (int j = 0; j < count; j++) begin
      r = $urandom_range(0, 99);
      if (r < 35) pending_items.push_back(submit_item(2'($urandom_range(0, 2))));
      else if (r < 45) pending_items.push_back(op_item(KIND_SET));
      else if (r < 55) pending_items.push_back(op_item(KIND_REMOVE));
      else if (r < 80) pending_items.push_back(op_item(KIND_TICK));
      else if (r < 83) pending_items.push_back(op_item(KIND_CLEAR));
      else if (r < 88) pending_items.push_back(op_item(KIND_ENABLE));
      else if (r < 96) pending_items.push_back(op_item(KIND_LOOKUP));
      else pending_items.push_back(noise_item());
    end
  endfunction

  initial begin
    in_t it;
    mix_reset();
    mismatches = 0;
    hold_sender = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every kind, extreme fields, full table, bad type
    it = submit_item(EFF_CONST); it.value_a = 16'sh7fff; it.duration = ENDLESS;
    it.channel = 1'b0; pending_items.push_back(it);
    it = submit_item(EFF_FADE); it.value_a = 16'sh7fff; it.duration = '0;
    it.channel = 1'b1; pending_items.push_back(it);
    it = submit_item(EFF_FADE); it.value_a = 16'sh4000; it.duration = 24'd100;
    it.channel = 1'b1; pending_items.push_back(it);
    it = submit_item(EFF_ALT); it.value_a = 16'sh8000; it.value_b = 16'sh1234;
    it.period_a = '0; it.period_b = '0; it.duration = 24'd50; it.start_second = 1'b1;
    pending_items.push_back(it);
    it = submit_item(EFF_BAD); pending_items.push_back(it);
    it = op_item(KIND_SET); it.request_id = 32'd4; it.value_a = 16'sh8000;
    pending_items.push_back(it);
    it = op_item(KIND_SET); it.request_id = 32'd1; it.value_a = 16'sh0100;
    pending_items.push_back(it);
    it = op_item(KIND_LOOKUP); it.request_id = 32'd3; pending_items.push_back(it);
    it = op_item(KIND_LOOKUP); it.request_id = 32'd0; pending_items.push_back(it);
    it = op_item(KIND_TICK); it.delta_time = 16'hffff; pending_items.push_back(it);
    it = op_item(KIND_ENABLE); it.enable_value = 1'b0; pending_items.push_back(it);
    it = op_item(KIND_TICK); it.delta_time = 16'd1; pending_items.push_back(it);
    it = op_item(KIND_ENABLE); it.enable_value = 1'b1; pending_items.push_back(it);
    it = op_item(KIND_REMOVE); it.request_id = 32'd1; pending_items.push_back(it);
    it = op_item(KIND_REMOVE); it.request_id = 32'hffffffff; pending_items.push_back(it);
    it = noise_item(); it.kind = 3'd7; pending_items.push_back(it);
    for (int j = 0; j < 17; j++) begin
      it = submit_item(EFF_CONST); it.duration = ENDLESS; pending_items.push_back(it);
    end
    it = op_item(KIND_CLEAR); pending_items.push_back(it);
    drain();

    // random phases with different idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        3: begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin send_idle_pct = $urandom_range(0, 50); recv_stall_pct = 30; end
      endcase
      queue_random(180);
      if (ph == 2) begin
        // pause the sender until every result is back
        while (pending_items.size() > 90) @(posedge clk);
        hold_sender = 1;
        while (in_valid || expected_beats.size() > 0) @(posedge clk);
        hold_sender = 0;
      end
      drain();
    end
    repeat (2000) @(posedge clk);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
